@@ hdl/srss_pkg.sv @@
// Shared types and constants for the SQL result stream scanner.
`timescale 1ns / 1ps
`default_nettype none
package srss_pkg;
  localparam int unsigned PosW = 32;
  localparam int unsigned RowW = 32;

  // Event codes.
  localparam logic [2:0] EV_ROWS_BEGIN = 3'd0;
  localparam logic [2:0] EV_ROW        = 3'd1;
  localparam logic [2:0] EV_RS_END     = 3'd2;
  localparam logic [2:0] EV_OK_END     = 3'd3;
  localparam logic [2:0] EV_ERROR      = 3'd4;

  // Register index of the only configuration register.
  localparam logic [0:0] REG_STOP_AFTER_FIRST = 1'b0;

  // One result item as it travels between the parser and the output buffer.
  typedef struct packed {
    logic [2:0]      event_res;
    logic [PosW-1:0] byte_pos;
    logic [RowW-1:0] row_count;
    logic            more_results;
    logic            finished;
  } event_t;

  // Queue depth between the front and the back: the event in flight plus two.
  localparam int unsigned QueueDepth = 3;
endpackage
`default_nettype wire

@@ hdl/sql_result_stream_scanner.sv @@
// Top level of the SQL result stream scanner.
// Input channel: one byte of the server response per item (in_valid/in_stall).
// Result channel: one event per item that completes an event (out_valid/out_stall),
//   with the byte position, the row count, the more-results bit and a finished
//   flag. After a finished event all later bytes are taken and ignored.
// Configuration: an APB-style port holds stop_after_first at address 0.
// Throughput: one byte per cycle while in_stall is low. The parser registers
// its event from the byte, and the event queue registers it before out_valid.
// A three-entry event queue sits between parser and output; the input stalls
// once two entries are held, so a stalled receiver never loses an event.
// Reset (synchronous, active low) returns to the start of a packet header,
// clears counters and the register, and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module sql_result_stream_scanner #(
  parameter int unsigned QueueDepth = srss_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_event_res,
  output logic [31:0]      out_byte_pos,
  output logic [31:0]      out_row_count,
  output logic             out_more_results,
  output logic             out_finished,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam logic [1:0] StopAddr = 2'(4 * srss_pkg::REG_STOP_AFTER_FIRST);

  logic stop_r;
  logic ev_valid;
  srss_pkg::event_t ev, q_ev;
  logic [$clog2(QueueDepth+1)-1:0] q_cnt;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == StopAddr) ? {31'd0, stop_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == StopAddr) begin
      stop_r <= cfg_pwdata[0];
    end
  end

  // Room for the event in flight plus one more.
  assign in_stall = (q_cnt >= ($clog2(QueueDepth+1))'(QueueDepth - 1));

  srss_parser u_parser (
    .clk(clk), .rst_n(rst_n), .stop_after_first(stop_r),
    .byte_valid(in_valid && !in_stall), .byte_data(in_data_byte),
    .ev_valid(ev_valid), .ev(ev)
  );

  srss_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(ev_valid), .push_ev(ev),
    .pop_stall(out_stall), .pop_valid(out_valid), .pop_ev(q_ev), .count(q_cnt)
  );

  assign out_event_res    = q_ev.event_res;
  assign out_byte_pos     = q_ev.byte_pos;
  assign out_row_count    = q_ev.row_count;
  assign out_more_results = q_ev.more_results;
  assign out_finished     = q_ev.finished;
endmodule
`default_nettype wire

@@ hdl/srss_parser.sv @@
// Front part: takes stream bytes and classifies them, producing events.
`timescale 1ns / 1ps
`default_nettype none
module srss_parser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           stop_after_first,
  input  wire logic           byte_valid,
  input  wire logic [7:0]     byte_data,
  output logic                ev_valid,
  output srss_pkg::event_t    ev
);
  typedef enum logic [4:0] {
    S_HDR, S_SEQ, S_FIRST, S_OK_A, S_OK_A_EXT, S_OK_B, S_OK_B_EXT, S_OK_STAT,
    S_OK_TAIL, S_ERR_TAIL, S_CNT_EXT, S_COL_LEN, S_COL_SKIP, S_CEOF, S_ROW_LEN,
    S_ROW_SKIP, S_EOF_SEQ, S_EOF_MARK, S_EOF_WARN, S_EOF_STAT
  } state_t;

  state_t      state_r, state_nxt;
  logic [23:0] plen_r, plen_nxt;
  logic [23:0] skip_r, skip_nxt;
  logic [23:0] fval_r, fval_nxt;
  logic [1:0]  fidx_r, fidx_nxt;
  logic [15:0] cols_r, cols_nxt;
  logic [31:0] rows_r, rows_nxt;
  logic [31:0] pos_r;
  logic        done_r, done_nxt;
  logic        evv_nxt;
  srss_pkg::event_t ev_nxt;
  logic [23:0] tb_val;
  logic [1:0]  tb_idx;
  logic [23:0] plen_dec;
  logic [23:0] skip_dec;
  logic [3:0]  lcb;
  logic        fin;

  // Little-endian field assembly; nonzero bytes past the third saturate the value.
  always_comb begin
    tb_val = fval_r;
    case (fidx_r)
      2'd0: tb_val = {16'd0, byte_data};
      2'd1: tb_val = {fval_r[23:16], byte_data, fval_r[7:0]};
      2'd2: tb_val = {byte_data, fval_r[15:0]};
      default: if (byte_data != 8'd0) tb_val = 24'hFFFFFF;
    endcase
    tb_idx = (fidx_r == 2'd3) ? fidx_r : fidx_r + 2'd1;
    plen_dec = (plen_r != 24'd0) ? plen_r - 24'd1 : plen_r;
    skip_dec = (skip_r != 24'd0) ? skip_r - 24'd1 : skip_r;
    case (byte_data)
      8'd252:  lcb = 4'd2;
      8'd253:  lcb = 4'd3;
      8'd254:  lcb = 4'd8;
      default: lcb = 4'd0;
    endcase
  end

  // Parse state update for one byte.
  always_comb begin
    state_nxt = state_r; plen_nxt = plen_r; skip_nxt = skip_r; fval_nxt = fval_r;
    fidx_nxt = fidx_r; cols_nxt = cols_r; rows_nxt = rows_r; done_nxt = done_r;
    evv_nxt = 1'b0; fin = 1'b0;
    ev_nxt = '{event_res: srss_pkg::EV_ROW, byte_pos: pos_r, row_count: '0,
               more_results: 1'b0, finished: 1'b0};
    case (state_r)
      S_HDR: begin
        fval_nxt = tb_val; fidx_nxt = tb_idx;
        if (tb_idx == 2'd3) begin
          plen_nxt = tb_val; state_nxt = S_SEQ;
        end
      end
      S_SEQ: state_nxt = S_FIRST;
      S_FIRST: begin
        plen_nxt = plen_dec;
        if (byte_data == 8'h00) begin
          state_nxt = S_OK_A;
        end else if (byte_data == 8'hFF) begin
          if (plen_dec == 24'd0) begin
            done_nxt = 1'b1; evv_nxt = 1'b1;
            ev_nxt.event_res = srss_pkg::EV_ERROR; ev_nxt.finished = 1'b1;
          end else begin
            state_nxt = S_ERR_TAIL;
          end
        end else if (lcb != 4'd0) begin
          skip_nxt = {20'd0, lcb}; fidx_nxt = 2'd0; state_nxt = S_CNT_EXT;
        end else begin
          fidx_nxt = 2'd0;
          cols_nxt = (byte_data < 8'd251) ? {8'd0, byte_data} : 16'd0;
          if (byte_data >= 8'd251 || byte_data == 8'd0) begin
            skip_nxt = 24'd8; state_nxt = S_CEOF;
          end else begin
            state_nxt = S_COL_LEN;
          end
        end
      end
      S_OK_A, S_OK_B: begin
        plen_nxt = plen_dec;
        if (lcb != 4'd0) begin
          skip_nxt = {20'd0, lcb};
          state_nxt = (state_r == S_OK_A) ? S_OK_A_EXT : S_OK_B_EXT;
        end else if (state_r == S_OK_A) begin
          state_nxt = S_OK_B;
        end else begin
          fidx_nxt = 2'd0; state_nxt = S_OK_STAT;
        end
      end
      S_OK_A_EXT, S_OK_B_EXT: begin
        plen_nxt = plen_dec; skip_nxt = skip_dec;
        if (skip_dec == 24'd0) begin
          if (state_r == S_OK_A_EXT) begin
            state_nxt = S_OK_B;
          end else begin
            fidx_nxt = 2'd0; state_nxt = S_OK_STAT;
          end
        end
      end
      S_OK_STAT: begin
        plen_nxt = plen_dec; fval_nxt = tb_val; fidx_nxt = tb_idx;
        if (tb_idx == 2'd2) begin
          if (plen_dec == 24'd0) begin
            fin = ~tb_val[3] | stop_after_first;
            done_nxt = fin; state_nxt = S_HDR; fidx_nxt = 2'd0; evv_nxt = 1'b1;
            ev_nxt.event_res = srss_pkg::EV_OK_END;
            ev_nxt.more_results = tb_val[3]; ev_nxt.finished = fin;
          end else begin
            state_nxt = S_OK_TAIL;
          end
        end
      end
      S_OK_TAIL: begin
        plen_nxt = plen_dec;
        if (plen_dec == 24'd0) begin
          fin = ~fval_r[3] | stop_after_first;
          done_nxt = fin; state_nxt = S_HDR; fidx_nxt = 2'd0; evv_nxt = 1'b1;
          ev_nxt.event_res = srss_pkg::EV_OK_END;
          ev_nxt.more_results = fval_r[3]; ev_nxt.finished = fin;
        end
      end
      S_ERR_TAIL: begin
        plen_nxt = plen_dec;
        if (plen_dec == 24'd0) begin
          done_nxt = 1'b1; evv_nxt = 1'b1;
          ev_nxt.event_res = srss_pkg::EV_ERROR; ev_nxt.finished = 1'b1;
        end
      end
      S_CNT_EXT: begin
        fval_nxt = tb_val; fidx_nxt = tb_idx; skip_nxt = skip_dec;
        if (skip_dec == 24'd0) begin
          cols_nxt = (tb_val > 24'hFFFF) ? 16'hFFFF : tb_val[15:0];
          fidx_nxt = 2'd0;
          if (tb_val == 24'd0) begin
            skip_nxt = 24'd8; state_nxt = S_CEOF;
          end else begin
            state_nxt = S_COL_LEN;
          end
        end
      end
      S_COL_LEN, S_ROW_LEN: begin
        fval_nxt = tb_val; fidx_nxt = tb_idx;
        if (tb_idx == 2'd3) begin
          skip_nxt = tb_val;
          if (state_r == S_COL_LEN) state_nxt = S_COL_SKIP;
          else if (tb_val == 24'd5) state_nxt = S_EOF_SEQ;
          else state_nxt = S_ROW_SKIP;
        end
      end
      S_COL_SKIP: begin
        if (skip_r != 24'd0) begin
          skip_nxt = skip_dec;
        end else begin
          cols_nxt = cols_r - 16'd1; fidx_nxt = 2'd0;
          if (cols_r == 16'd1) begin
            skip_nxt = 24'd8; state_nxt = S_CEOF;
          end else begin
            state_nxt = S_COL_LEN;
          end
        end
      end
      S_CEOF: begin
        if (skip_r != 24'd0) begin
          skip_nxt = skip_dec;
        end else begin
          rows_nxt = '0; evv_nxt = 1'b1; fidx_nxt = 2'd0; state_nxt = S_ROW_LEN;
          ev_nxt.event_res = srss_pkg::EV_ROWS_BEGIN;
        end
      end
      S_ROW_SKIP: begin
        if (skip_r != 24'd0) begin
          skip_nxt = skip_dec;
        end else begin
          if (rows_r != 32'hFFFFFFFF) rows_nxt = rows_r + 32'd1;
          evv_nxt = 1'b1; fidx_nxt = 2'd0; state_nxt = S_ROW_LEN;
          ev_nxt.event_res = srss_pkg::EV_ROW; ev_nxt.row_count = rows_nxt;
        end
      end
      S_EOF_SEQ: state_nxt = S_EOF_MARK;
      S_EOF_MARK: begin
        fidx_nxt = 2'd0;
        if (byte_data == 8'hFE) begin
          state_nxt = S_EOF_WARN;
        end else begin
          skip_nxt = 24'd3; state_nxt = S_ROW_SKIP;
        end
      end
      S_EOF_WARN: begin
        fval_nxt = tb_val; fidx_nxt = tb_idx;
        if (tb_idx == 2'd2) begin
          fidx_nxt = 2'd0; state_nxt = S_EOF_STAT;
        end
      end
      S_EOF_STAT: begin
        fval_nxt = tb_val; fidx_nxt = tb_idx;
        if (tb_idx == 2'd2) begin
          fin = ~tb_val[3] | stop_after_first;
          done_nxt = fin; state_nxt = S_HDR; fidx_nxt = 2'd0; evv_nxt = 1'b1;
          ev_nxt.event_res = srss_pkg::EV_RS_END; ev_nxt.row_count = rows_r;
          ev_nxt.more_results = tb_val[3]; ev_nxt.finished = fin;
        end
      end
      default: begin
        state_nxt = S_HDR; fidx_nxt = 2'd0;
      end
    endcase
  end

  // State registers; nothing changes once parsing has finished.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HDR; plen_r <= '0; skip_r <= '0; fval_r <= '0; fidx_r <= '0;
      cols_r <= '0; rows_r <= '0; pos_r <= '0; done_r <= 1'b0; ev_valid <= 1'b0;
    end else begin
      ev_valid <= 1'b0;
      if (byte_valid && !done_r) begin
        state_r <= state_nxt; plen_r <= plen_nxt; skip_r <= skip_nxt;
        fval_r <= fval_nxt; fidx_r <= fidx_nxt; cols_r <= cols_nxt;
        rows_r <= rows_nxt; pos_r <= pos_r + 32'd1; done_r <= done_nxt;
        ev_valid <= evv_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !done_r) ev <= ev_nxt;
  end
endmodule
`default_nettype wire

@@ hdl/srss_queue.sv @@
// Back part: a small queue of events that drives the result channel.
`timescale 1ns / 1ps
`default_nettype none
module srss_queue #(
  parameter int unsigned Depth = srss_pkg::QueueDepth
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire srss_pkg::event_t push_ev,
  input  wire logic             pop_stall,
  output logic                  pop_valid,
  output srss_pkg::event_t      pop_ev,
  output logic [$clog2(Depth+1)-1:0] count
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth+1);
  srss_pkg::event_t mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic pop;

  assign pop_valid = (cnt_r != '0);
  assign pop_ev = mem_r[rp_r];
  assign pop = pop_valid && !pop_stall;
  assign count = cnt_r;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + AW'(1);
      if (pop) rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_ev;
  end
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the SQL result stream scanner.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  localparam int unsigned CycleLimit = 600000;

  // Parser states of the scanner, as the predictor tracks them.
  typedef enum int unsigned {
    S_HDR, S_SEQ, S_FIRST, S_OK_A, S_OK_A_EXT, S_OK_B, S_OK_B_EXT, S_OK_STAT,
    S_OK_TAIL, S_ERR_TAIL, S_CNT_EXT, S_COL_LEN, S_COL_SKIP, S_CEOF, S_ROW_LEN,
    S_ROW_SKIP, S_EOF_SEQ, S_EOF_MARK, S_EOF_WARN, S_EOF_STAT
  } scan_state_t;

  // Byte values with a meaning in the protocol.
  localparam logic [7:0] B_OK      = 8'h00;
  localparam logic [7:0] B_NULL    = 8'd251;
  localparam logic [7:0] B_LEN2    = 8'd252;
  localparam logic [7:0] B_LEN3    = 8'd253;
  localparam logic [7:0] B_LEN8    = 8'd254;
  localparam logic [7:0] B_ERR     = 8'hFF;
  localparam logic [7:0] B_EOF     = 8'hFE;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_res;
  logic [31:0] out_byte_pos;
  logic [31:0] out_row_count;
  logic        out_more_results;
  logic        out_finished;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sql_result_stream_scanner dut (.*);

  always #6 clk = ~clk;

  // Predictor state.
  scan_state_t ps;
  logic [23:0] pkt_len, skip_cnt, fld;
  logic [1:0]  fld_idx;
  logic [15:0] cols;
  logic [31:0] rows, offset;
  logic        done, stop_cfg;

  logic [7:0]  wire_bytes[$];
  srss_pkg::event_t pending_events[$];
  int unsigned idle_pct = 0, stall_pct = 0;
  int unsigned errors = 0, cycles = 0;
  logic        byte_taken = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Appends one byte to a byte list.
  function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] b);
    q.insert(q.size(), b);
  endfunction

  // Appends one byte to the send queue.
  function automatic void put_byte(input logic [7:0] b);
    wire_bytes.insert(wire_bytes.size(), b);
  endfunction

  function automatic logic [23:0] len_code_extra(input logic [7:0] b);
    if (b == B_LEN2) return 24'd2;
    if (b == B_LEN3) return 24'd3;
    if (b == B_LEN8) return 24'd8;
    return 24'd0;
  endfunction

  // Little-endian field assembly; nonzero bytes past the third only saturate.
  function automatic void take_field_byte(input logic [7:0] b);
    if (fld_idx == 2'd0) fld = 24'(b);
    else if (fld_idx < 2'd3) fld = fld | (24'(b) << (8 * fld_idx));
    else if (b != 8'd0) fld = 24'hFFFFFF;
    if (fld_idx < 2'd3) fld_idx++;
  endfunction

  function automatic void count_down_payload();
    if (pkt_len != 24'd0) pkt_len--;
  endfunction

  function automatic srss_pkg::event_t make_event(input logic [2:0] code,
                                                  input logic [31:0] n,
                                                  input logic more, input logic fin);
    srss_pkg::event_t ev;
    ev.event_res = code;
    ev.byte_pos = offset;
    ev.row_count = n;
    ev.more_results = more;
    ev.finished = fin;
    return ev;
  endfunction

  function automatic logic close_response(input logic more);
    logic fin;
    fin = !more || stop_cfg;
    done = fin;
    ps = S_HDR;
    fld_idx = 2'd0;
    return fin;
  endfunction

  function automatic void open_columns(input logic [23:0] v);
    cols = (v > 24'hFFFF) ? 16'hFFFF : v[15:0];
    fld_idx = 2'd0;
    if (cols == 16'd0) begin
      skip_cnt = 24'd8;
      ps = S_CEOF;
    end else begin
      ps = S_COL_LEN;
    end
  endfunction

  // Advances the predicted scanner by one byte; returns 1 with the event it causes.
  function automatic bit scan_byte(input logic [7:0] b, output srss_pkg::event_t ev);
    bit hit;
    logic more, fin;
    hit = 1'b0;
    ev = '0;
    if (done) return 1'b0;
    case (ps)
      S_HDR: begin
        take_field_byte(b);
        if (fld_idx == 2'd3) begin
          pkt_len = fld;
          ps = S_SEQ;
        end
      end
      S_SEQ: ps = S_FIRST;
      S_FIRST: begin
        count_down_payload();
        if (b == B_OK) begin
          ps = S_OK_A;
        end else if (b == B_ERR) begin
          if (pkt_len == 24'd0) begin
            done = 1'b1;
            ev = make_event(srss_pkg::EV_ERROR, 0, 1'b0, 1'b1);
            hit = 1'b1;
          end else begin
            ps = S_ERR_TAIL;
          end
        end else if (len_code_extra(b) != 24'd0) begin
          skip_cnt = len_code_extra(b);
          fld_idx = 2'd0;
          ps = S_CNT_EXT;
        end else begin
          open_columns(b < B_NULL ? 24'(b) : 24'd0);
        end
      end
      S_OK_A, S_OK_B: begin
        count_down_payload();
        if (len_code_extra(b) != 24'd0) begin
          skip_cnt = len_code_extra(b);
          ps = (ps == S_OK_A) ? S_OK_A_EXT : S_OK_B_EXT;
        end else if (ps == S_OK_A) begin
          ps = S_OK_B;
        end else begin
          fld_idx = 2'd0;
          ps = S_OK_STAT;
        end
      end
      S_OK_A_EXT, S_OK_B_EXT: begin
        count_down_payload();
        if (skip_cnt != 24'd0) skip_cnt--;
        if (skip_cnt == 24'd0) begin
          if (ps == S_OK_A_EXT) begin
            ps = S_OK_B;
          end else begin
            fld_idx = 2'd0;
            ps = S_OK_STAT;
          end
        end
      end
      S_OK_STAT: begin
        count_down_payload();
        take_field_byte(b);
        if (fld_idx == 2'd2) begin
          if (pkt_len == 24'd0) begin
            more = fld[3];
            fin = close_response(more);
            ev = make_event(srss_pkg::EV_OK_END, 0, more, fin);
            hit = 1'b1;
          end else begin
            ps = S_OK_TAIL;
          end
        end
      end
      S_OK_TAIL: begin
        count_down_payload();
        if (pkt_len == 24'd0) begin
          more = fld[3];
          fin = close_response(more);
          ev = make_event(srss_pkg::EV_OK_END, 0, more, fin);
          hit = 1'b1;
        end
      end
      S_ERR_TAIL: begin
        count_down_payload();
        if (pkt_len == 24'd0) begin
          done = 1'b1;
          ev = make_event(srss_pkg::EV_ERROR, 0, 1'b0, 1'b1);
          hit = 1'b1;
        end
      end
      S_CNT_EXT: begin
        take_field_byte(b);
        if (skip_cnt != 24'd0) skip_cnt--;
        if (skip_cnt == 24'd0) open_columns(fld);
      end
      S_COL_LEN, S_ROW_LEN: begin
        take_field_byte(b);
        if (fld_idx == 2'd3) begin
          skip_cnt = fld;
          if (ps == S_COL_LEN) ps = S_COL_SKIP;
          else if (skip_cnt == 24'd5) ps = S_EOF_SEQ;
          else ps = S_ROW_SKIP;
        end
      end
      S_COL_SKIP: begin
        if (skip_cnt != 24'd0) begin
          skip_cnt--;
        end else begin
          cols--;
          fld_idx = 2'd0;
          if (cols == 16'd0) begin
            skip_cnt = 24'd8;
            ps = S_CEOF;
          end else begin
            ps = S_COL_LEN;
          end
        end
      end
      S_CEOF: begin
        if (skip_cnt != 24'd0) begin
          skip_cnt--;
        end else begin
          rows = 0;
          ev = make_event(srss_pkg::EV_ROWS_BEGIN, 0, 1'b0, 1'b0);
          hit = 1'b1;
          fld_idx = 2'd0;
          ps = S_ROW_LEN;
        end
      end
      S_ROW_SKIP: begin
        if (skip_cnt != 24'd0) begin
          skip_cnt--;
        end else begin
          if (rows != 32'hFFFFFFFF) rows++;
          ev = make_event(srss_pkg::EV_ROW, rows, 1'b0, 1'b0);
          hit = 1'b1;
          fld_idx = 2'd0;
          ps = S_ROW_LEN;
        end
      end
      S_EOF_SEQ: ps = S_EOF_MARK;
      S_EOF_MARK: begin
        fld_idx = 2'd0;
        if (b == B_EOF) begin
          ps = S_EOF_WARN;
        end else begin
          skip_cnt = 24'd3;
          ps = S_ROW_SKIP;
        end
      end
      S_EOF_WARN: begin
        take_field_byte(b);
        if (fld_idx == 2'd2) begin
          fld_idx = 2'd0;
          ps = S_EOF_STAT;
        end
      end
      S_EOF_STAT: begin
        take_field_byte(b);
        if (fld_idx == 2'd2) begin
          more = fld[3];
          fin = close_response(more);
          ev = make_event(srss_pkg::EV_RS_END, rows, more, fin);
          hit = 1'b1;
        end
      end
      default: begin
        ps = S_HDR;
        fld_idx = 2'd0;
      end
    endcase
    offset++;
    return hit;
  endfunction

  // Stream builders: each appends the bytes of packets to the send queue.
  function automatic void put_len3(input int unsigned n);
    put_byte(n[7:0]);
    put_byte(n[15:8]);
    put_byte(n[23:16]);
  endfunction

  function automatic void put_hdr(input int unsigned n);
    put_len3(n);
    put_byte(8'($urandom));
  endfunction

  // Length-coded value in a random legal form into a byte list.
  function automatic void put_code(ref logic [7:0] p[$], input int unsigned v);
    int unsigned form;
    form = $urandom_range(3);
    if (v < 251 && form == 0) begin
      add_byte(p, 8'(v));
    end else if (v < 65536 && form < 2) begin
      add_byte(p, B_LEN2);
      add_byte(p, v[7:0]);
      add_byte(p, v[15:8]);
    end else if (form < 3) begin
      add_byte(p, B_LEN3);
      for (int i = 0; i < 3; i++) add_byte(p, 8'(v >> (8 * i)));
    end else begin
      add_byte(p, B_LEN8);
      for (int i = 0; i < 8; i++) add_byte(p, i < 3 ? 8'(v >> (8 * i)) : 8'd0);
    end
  endfunction

  function automatic void put_ok(input logic more);
    logic [7:0] p[$];
    int unsigned stat_end, len;
    logic [7:0] st;
    add_byte(p, B_OK);
    put_code(p, $urandom_range(3) == 0 ? $urandom : $urandom_range(300));
    put_code(p, $urandom_range(300));
    st = 8'($urandom);
    st[3] = more;
    add_byte(p, st);
    add_byte(p, 8'($urandom));
    stat_end = p.size();
    len = p.size();
    if ($urandom_range(3) == 0) begin
      // Length field that may be shorter than the fields actually sent.
      len = $urandom_range(stat_end);
    end else begin
      repeat ($urandom_range(5)) add_byte(p, 8'($urandom));
      len = p.size();
    end
    put_hdr(len);
    foreach (p[i]) put_byte(p[i]);
  endfunction

  function automatic void put_err(input int unsigned len);
    put_hdr(len);
    put_byte(B_ERR);
    for (int unsigned i = 1; i < len; i++) put_byte(8'($urandom));
  endfunction

  function automatic void put_result_set(input logic more, input int unsigned ncol,
                                         input int unsigned nrows);
    logic [7:0] p[$];
    logic [7:0] st;
    int unsigned r;
    if (ncol == 0) begin
      // A zero count is sent as a null code or a two-byte code; 0x00 means OK.
      if ($urandom_range(1) == 0) begin
        add_byte(p, B_NULL);
      end else begin
        add_byte(p, B_LEN2);
        add_byte(p, 8'd0);
        add_byte(p, 8'd0);
      end
    end else begin
      put_code(p, ncol);
      // A first byte of 0x00 or 0xFF would not start a result set.
      if (p[0] == B_OK) p[0] = 8'(ncol);
    end
    put_hdr(p.size());
    foreach (p[i]) put_byte(p[i]);
    repeat (ncol) begin
      r = $urandom_range(10);
      put_hdr(r);
      repeat (r) put_byte(8'($urandom));
    end
    put_hdr(5);
    put_byte(B_EOF);
    repeat (4) put_byte(8'($urandom));
    repeat (nrows) begin
      r = $urandom_range(12);
      put_hdr(r);
      for (int unsigned i = 0; i < r; i++) begin
        // A five-byte row that starts with the EOF marker would end the set.
        if (r == 5 && i == 0) put_byte(8'($urandom_range(253)));
        else put_byte(8'($urandom));
      end
    end
    put_hdr(5);
    put_byte(B_EOF);
    put_byte(8'($urandom));
    put_byte(8'($urandom));
    st = 8'($urandom);
    st[3] = more;
    put_byte(st);
    put_byte(8'($urandom));
  endfunction

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic cfg_write(input logic [0:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 2'(4 * idx);
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (idx == srss_pkg::REG_STOP_AFTER_FIRST) stop_cfg = value[0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (wire_bytes.size() != 0 || in_valid || pending_events.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Byte driver.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (wire_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_data_byte <= wire_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    byte_taken <= 1'b0;
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Accepted bytes feed the predictor; accepted events are checked.
  always @(posedge clk) begin
    srss_pkg::event_t ev, exp_ev;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("** sql_result_stream_scanner: FAILED **");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) begin
      byte_taken <= 1'b1;
      if (scan_byte(in_data_byte, ev)) pending_events.insert(pending_events.size(), ev);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event %0d at pos %0d", out_event_res,
                                  out_byte_pos));
      end else begin
        exp_ev = pending_events.pop_front();
        if (out_event_res !== exp_ev.event_res)
          report_mismatch($sformatf("event_res %0d, expected %0d", out_event_res,
                                    exp_ev.event_res));
        if (out_byte_pos !== exp_ev.byte_pos)
          report_mismatch($sformatf("byte_pos %0d, expected %0d", out_byte_pos,
                                    exp_ev.byte_pos));
        if (out_row_count !== exp_ev.row_count)
          report_mismatch($sformatf("row_count %0d, expected %0d", out_row_count,
                                    exp_ev.row_count));
        if (out_more_results !== exp_ev.more_results)
          report_mismatch($sformatf("more_results %0b, expected %0b", out_more_results,
                                    exp_ev.more_results));
        if (out_finished !== exp_ev.finished)
          report_mismatch($sformatf("finished %0b, expected %0b", out_finished,
                                    exp_ev.finished));
      end
    end
  end

  // Stimulus: directed responses, random phases under varying idling and output stalls, then the end.
  initial begin
    int unsigned start_len;
    ps = S_HDR;
    pkt_len = '0;
    skip_cnt = '0;
    fld = '0;
    fld_idx = '0;
    cols = '0;
    rows = '0;
    offset = '0;
    done = 1'b0;
    stop_cfg = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    cfg_write(srss_pkg::REG_STOP_AFTER_FIRST, 32'd0);

    // Directed: a zero-column set, an OK response and a one-column set.
    put_result_set(1'b1, 0, 2);
    put_ok(1'b1);
    put_result_set(1'b1, 1, 3);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      start_len = wire_bytes.size();
      while (wire_bytes.size() - start_len < 190) begin
        if ($urandom_range(9) < 3) put_ok(1'b1);
        else put_result_set(1'b1, $urandom_range(3), $urandom_range(6));
      end
      wait_drained();
      cfg_write(srss_pkg::REG_STOP_AFTER_FIRST, 32'd0);
    end

    // Final response ends parsing; the bytes after it must be ignored.
    cfg_write(srss_pkg::REG_STOP_AFTER_FIRST, 32'd1);
    case ($urandom_range(3))
      0: put_err($urandom_range(2));
      1: put_err($urandom_range(3, 20));
      2: put_ok($urandom_range(1));
      default: put_result_set($urandom_range(1), $urandom_range(3), $urandom_range(4));
    endcase
    put_result_set(1'b1, 1, 2);
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** sql_result_stream_scanner: PASSED **");
    end else begin
      $display("** sql_result_stream_scanner: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
